>>> rtl/rdq_pkg.sv
// shared types, message layout constants and digit helper for the reverse dns query builder
package rdq_pkg;

  localparam int NUM_SLOTS = 46;

  // fixed slot positions in the message template
  localparam int SLOT_OCTET0   = 12;
  localparam int SLOT_IN_ADDR  = 28;
  localparam int SLOT_ARPA     = 36;
  localparam int SLOT_ROOT     = 41;
  localparam int SLOT_QTYPE    = 42;
  localparam int SLOT_QCLASS   = 44;

  localparam int LEN_IN_ADDR = 7;
  localparam int LEN_ARPA    = 4;

  localparam logic [7:0] PTR_QTYPE = 8'd12;
  localparam logic [7:0] IN_QCLASS = 8'd1;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // "in-addr" and "arpa"
  localparam logic [7:0] IN_ADDR_LABEL [LEN_IN_ADDR] =
    '{8'h69, 8'h6e, 8'h2d, 8'h61, 8'h64, 8'h64, 8'h72};
  localparam logic [7:0] ARPA_LABEL [LEN_ARPA] = '{8'h61, 8'h72, 8'h70, 8'h61};

  typedef struct packed {
    logic       emit;
    logic       last;
    logic [7:0] data;
  } cell_t;

  typedef struct packed {
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [1:0] count;
  } digits_t;

  function automatic digits_t octet_digits(input logic [7:0] v);
    digits_t    d;
    logic [7:0] sub;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [6:0] tens_x10;
    logic [6:0] ones_w;
    d.hundreds = (v >= 8'd200) ? 2'd2 : (v >= 8'd100) ? 2'd1 : 2'd0;
    sub = (v >= 8'd200) ? 8'd200 : (v >= 8'd100) ? 8'd100 : 8'd0;
    rem = 7'(v - sub);
    // divide by ten through a reciprocal, exact for values below 100
    prod = 15'(rem) * 15'd205;
    d.tens = prod[14:11];
    tens_x10 = 7'(d.tens) * 7'd10;
    ones_w = rem - tens_x10;
    d.ones = ones_w[3:0];
    d.count = 2'd1 + ((v >= 8'd10) ? 2'd1 : 2'd0) + ((v >= 8'd100) ? 2'd1 : 2'd0);
    return d;
  endfunction

endpackage

>>> rtl/rdq_template.sv
// builds the fixed 46-slot message template from an address and the transaction id
module rdq_template
  import rdq_pkg::*;
(
  input  logic [31:0] address,
  input  logic [15:0] transaction_id,
  output cell_t       slots [NUM_SLOTS]
);

  // header
  assign slots[0] = '{emit: 1'b1, last: 1'b0, data: transaction_id[15:8]};
  assign slots[1] = '{emit: 1'b1, last: 1'b0, data: transaction_id[7:0]};
  assign slots[2] = '{emit: 1'b1, last: 1'b0, data: 8'd0};
  assign slots[3] = '{emit: 1'b1, last: 1'b0, data: 8'd0};
  assign slots[4] = '{emit: 1'b1, last: 1'b0, data: 8'd0};
  assign slots[5] = '{emit: 1'b1, last: 1'b0, data: 8'd1};

  genvar g;
  generate
    for (g = 6; g < SLOT_OCTET0; g++) begin : g_hdr_zero
      assign slots[g] = '{emit: 1'b1, last: 1'b0, data: 8'd0};
    end

    // octet labels, last dotted octet first; leading zero digits become skipped slots
    for (g = 0; g < 4; g++) begin : g_octet
      digits_t dg;
      assign dg = octet_digits(address[8*g +: 8]);
      assign slots[SLOT_OCTET0 + 4*g] = '{emit: 1'b1, last: 1'b0, data: {6'd0, dg.count}};
      assign slots[SLOT_OCTET0 + 4*g + 1] =
        '{emit: (dg.count == 2'd3), last: 1'b0, data: CHAR_ZERO | {6'd0, dg.hundreds}};
      assign slots[SLOT_OCTET0 + 4*g + 2] =
        '{emit: (dg.count != 2'd1), last: 1'b0, data: CHAR_ZERO | {4'd0, dg.tens}};
      assign slots[SLOT_OCTET0 + 4*g + 3] =
        '{emit: 1'b1, last: 1'b0, data: CHAR_ZERO | {4'd0, dg.ones}};
    end

    for (g = 0; g < LEN_IN_ADDR; g++) begin : g_in_addr
      assign slots[SLOT_IN_ADDR + 1 + g] = '{emit: 1'b1, last: 1'b0, data: IN_ADDR_LABEL[g]};
    end

    for (g = 0; g < LEN_ARPA; g++) begin : g_arpa
      assign slots[SLOT_ARPA + 1 + g] = '{emit: 1'b1, last: 1'b0, data: ARPA_LABEL[g]};
    end
  endgenerate

  assign slots[SLOT_IN_ADDR]   = '{emit: 1'b1, last: 1'b0, data: 8'(LEN_IN_ADDR)};
  assign slots[SLOT_ARPA]      = '{emit: 1'b1, last: 1'b0, data: 8'(LEN_ARPA)};
  assign slots[SLOT_ROOT]      = '{emit: 1'b1, last: 1'b0, data: 8'd0};
  assign slots[SLOT_QTYPE]     = '{emit: 1'b1, last: 1'b0, data: 8'd0};
  assign slots[SLOT_QTYPE + 1] = '{emit: 1'b1, last: 1'b0, data: PTR_QTYPE};
  assign slots[SLOT_QCLASS]    = '{emit: 1'b1, last: 1'b0, data: 8'd0};
  assign slots[SLOT_QCLASS + 1] = '{emit: 1'b1, last: 1'b1, data: IN_QCLASS};

endmodule

>>> rtl/rdq_cell.sv
// one byte cell of the output shift chain
module rdq_cell
  import rdq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  logic  adv,
  input  cell_t load_cell,
  input  logic  up_occ,
  input  cell_t up_cell,
  output logic  occ,
  output cell_t slot_out
);

  logic  occ_r, occ_nxt;
  cell_t cell_r, cell_nxt;

  always_comb begin
    occ_nxt  = occ_r;
    cell_nxt = cell_r;
    if (load) begin
      occ_nxt  = 1'b1;
      cell_nxt = load_cell;
    end else if (adv) begin
      occ_nxt  = up_occ;
      cell_nxt = up_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign occ      = occ_r;
  assign slot_out = cell_r;

endmodule

>>> rtl/reverse_dns_query_builder.sv
// top level: dns ptr query generator built as a 46-cell byte shift chain
// the first byte of a query is offered in the cycle after the address transaction
// the chain moves one slot a cycle unless a stalled head byte holds it, and slots of
//   suppressed leading zero digits pass as bubbles, so a query carries 38 to 46 bytes
// the next address is taken in the cycle the final byte of the previous query leaves
// reset: transaction id returns to 1 and every cell of the chain is emptied
module reverse_dns_query_builder
  import rdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_transaction_id,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_query_byte,
  output logic        out_last_byte
);

  logic [15:0] tid_r, tid_nxt;

  always_comb begin
    tid_nxt = cfg_write_en ? cfg_transaction_id : tid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_r <= 16'd1;
    end else begin
      tid_r <= tid_nxt;
    end
  end

  cell_t             tmpl [NUM_SLOTS];
  cell_t             chain_w [NUM_SLOTS+1];
  logic [NUM_SLOTS:0] occ_v;
  logic              adv;
  logic              load;

  rdq_template u_template (
    .address        (in_address),
    .transaction_id (tid_r),
    .slots          (tmpl)
  );

  // a stalled head byte holds the chain; bubbles always move on
  assign adv  = !(occ_v[0] && chain_w[0].emit && out_stall);
  // occupancy is contiguous from the head, so the chain frees up once cell 1 is empty and the head is not stalled
  assign in_stall = occ_v[1] || (occ_v[0] && !adv);
  assign load = in_valid && !in_stall;

  assign occ_v[NUM_SLOTS]   = 1'b0;
  assign chain_w[NUM_SLOTS] = '0;

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      rdq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .adv       (adv),
        .load_cell (tmpl[g]),
        .up_occ    (occ_v[g+1]),
        .up_cell   (chain_w[g+1]),
        .occ       (occ_v[g]),
        .slot_out  (chain_w[g])
      );
    end
  endgenerate

  assign out_valid      = occ_v[0] && chain_w[0].emit;
  assign out_query_byte = chain_w[0].data;
  assign out_last_byte  = chain_w[0].last;

  logic [NUM_SLOTS+1:0] occ_plus1;
  assign occ_plus1 = {1'b0, occ_v} + {{(NUM_SLOTS+1){1'b0}}, 1'b1};

  // a new query opens with the high byte of the id in force at acceptance
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (out_valid && out_query_byte == $past(tid_r[15:8])))
    else $error("query does not start with transaction id high byte");

  // occupied cells always form one run starting at the head
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(occ_plus1))
    else $error("chain occupancy is not contiguous");

  // the final byte sits alone in the chain
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |-> !occ_v[1])
    else $error("final byte has followers in the chain");

  // a query's final byte is followed by the new one only after it leaves
  a_no_accept_early: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte && out_stall) |-> in_stall)
    else $error("address taken while final byte is stalled");

endmodule

>>> tb/rdq_query_checker.sv
// checker for the reverse dns query builder: tracks the id, predicts every byte, compares
`timescale 1ns / 1ps

module rdq_query_checker
  import rdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_transaction_id,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_query_byte,
  input  logic        out_last_byte,
  output int          mismatches,
  output int          bytes_outstanding
);

  localparam logic [15:0] TXID_AT_RESET  = 16'd1;
  localparam logic [7:0]  QUESTION_COUNT = 8'd1;
  localparam int          HEADER_ZEROS   = 6;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       last_byte;
  } query_beat_t;

  logic [15:0] txid_model;
  query_beat_t query_bytes_due[$];

  initial begin
    mismatches = 0;
    bytes_outstanding = 0;
    txid_model = TXID_AT_RESET;
  end

  // queue the whole ptr query for one address, final byte flagged
  function automatic void queue_ptr_query(input logic [15:0] txid, input logic [31:0] addr);
    logic [7:0]  msg[$];
    logic [7:0]  octet;
    query_beat_t beat;
    msg.push_back(txid[15:8]);
    msg.push_back(txid[7:0]);
    msg.push_back(8'd0);
    msg.push_back(8'd0);
    msg.push_back(8'd0);
    msg.push_back(QUESTION_COUNT);
    for (int i = 0; i < HEADER_ZEROS; i++) msg.push_back(8'd0);
    // reversed octets, decimal without leading zeros
    for (int k = 0; k < 4; k++) begin
      octet = addr[8*k +: 8];
      if (octet >= 8'd100) begin
        msg.push_back(8'd3);
        msg.push_back(8'(CHAR_ZERO + octet / 8'd100));
        msg.push_back(8'(CHAR_ZERO + (octet / 8'd10) % 8'd10));
      end else if (octet >= 8'd10) begin
        msg.push_back(8'd2);
        msg.push_back(8'(CHAR_ZERO + octet / 8'd10));
      end else begin
        msg.push_back(8'd1);
      end
      msg.push_back(8'(CHAR_ZERO + octet % 8'd10));
    end
    msg.push_back(8'(LEN_IN_ADDR));
    for (int i = 0; i < LEN_IN_ADDR; i++) msg.push_back(IN_ADDR_LABEL[i]);
    msg.push_back(8'(LEN_ARPA));
    for (int i = 0; i < LEN_ARPA; i++) msg.push_back(ARPA_LABEL[i]);
    msg.push_back(8'd0);
    msg.push_back(8'd0);
    msg.push_back(PTR_QTYPE);
    msg.push_back(8'd0);
    msg.push_back(IN_QCLASS);
    for (int i = 0; i < msg.size(); i++) begin
      beat.query_byte = msg[i];
      beat.last_byte = (i == msg.size() - 1);
      query_bytes_due.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    query_beat_t due;
    if (!rst_n) begin
      txid_model = TXID_AT_RESET;
    end else begin
      // an address taken at the same edge as a write still sees the old id
      if (in_valid && !in_stall) queue_ptr_query(txid_model, in_address);
      if (cfg_write_en) txid_model = cfg_transaction_id;
      if (out_valid && !out_stall) begin
        if (query_bytes_due.size() == 0) begin
          $display("%0t: unexpected query byte, expected none, actual byte %02h last %0b",
                   $time, out_query_byte, out_last_byte);
          mismatches++;
        end else begin
          due = query_bytes_due.pop_front();
          if (out_query_byte !== due.query_byte) begin
            $display("%0t: query byte mismatch, expected %02h, actual %02h",
                     $time, due.query_byte, out_query_byte);
            mismatches++;
          end
          if (out_last_byte !== due.last_byte) begin
            $display("%0t: last byte flag mismatch, expected %0b, actual %0b",
                     $time, due.last_byte, out_last_byte);
            mismatches++;
          end
        end
      end
    end
    bytes_outstanding = query_bytes_due.size();
  end

endmodule

>>> tb/reverse_dns_query_builder_test.sv
// top of the reverse dns query builder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module reverse_dns_query_builder_test;

  localparam int IDLE_PERCENT   = 37;
  localparam int HOLD_OFF_TICKS = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_TICKS    = 50;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [15:0] cfg_transaction_id;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_address;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_query_byte;
  logic        out_last_byte;

  int   mismatches;
  int   bytes_outstanding;
  int   quiet_ticks;
  logic tx_idles;
  logic rx_idles;
  logic hold_off_req;
  logic hold_off_done;

  reverse_dns_query_builder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_transaction_id (cfg_transaction_id),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_query_byte     (out_query_byte),
    .out_last_byte      (out_last_byte)
  );

  rdq_query_checker query_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_transaction_id (cfg_transaction_id),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_query_byte     (out_query_byte),
    .out_last_byte      (out_last_byte),
    .mismatches         (mismatches),
    .bytes_outstanding  (bytes_outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: cycles with no transaction on either channel
  initial quiet_ticks = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_ticks = 0;
    else quiet_ticks++;
    if (quiet_ticks >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_TICKS) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_stall = rx_idles && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_address(input logic [31:0] addr);
    if (tx_idles) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid = 1'b0;
        in_address = $urandom;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_address = addr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sender pauses until every query byte has left, then writes the transaction id
  task automatic write_txid(input logic [15:0] txid);
    in_valid = 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_transaction_id = txid;
    @(negedge clk);
    cfg_write_en = 1'b0;
    cfg_transaction_id = 16'($urandom);
  endtask

  // octets biased toward the one, two and three digit boundaries
  function automatic logic [31:0] pick_address();
    logic [31:0] addr;
    addr = $urandom;
    if ($urandom_range(1) == 0) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(3))
          0: addr[8*k +: 8] = 8'($urandom_range(9));
          1: addr[8*k +: 8] = 8'($urandom_range(99, 10));
          2: addr[8*k +: 8] = 8'($urandom_range(255, 100));
          default: begin
            case ($urandom_range(5))
              0: addr[8*k +: 8] = 8'd0;
              1: addr[8*k +: 8] = 8'd9;
              2: addr[8*k +: 8] = 8'd10;
              3: addr[8*k +: 8] = 8'd99;
              4: addr[8*k +: 8] = 8'd100;
              default: addr[8*k +: 8] = 8'd255;
            endcase
          end
        endcase
      end
    end
    return addr;
  endfunction

  logic [31:0] directed_addrs[$] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h01020304, 32'hC0A80101, 32'h0A000001,
    32'h090A6364, 32'h64630A09, 32'hC7C8FF00, 32'h80808080, 32'h7F7F7F7F,
    32'h01010101, 32'h00FF00FF, 32'hFF00FF00, 32'h08080808, 32'hAC10FE01,
    32'h63646364, 32'hFE0A0009, 32'h5A5A5AA5, 32'hA5A5A55A, 32'h0000FFFF
  };

  initial begin
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_transaction_id = 16'd0;
    in_valid = 1'b0;
    in_address = 32'd0;
    tx_idles = 1'b1;
    rx_idles = 1'b1;
    hold_off_req = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // transaction id left at its reset value
    foreach (directed_addrs[i]) send_address(directed_addrs[i]);

    write_txid(16'hFFFF);
    repeat (110) send_address(pick_address());

    // back-to-back stretch, neither side idles
    write_txid(16'h0000);
    tx_idles = 1'b0;
    rx_idles = 1'b0;
    repeat (110) send_address(pick_address());
    tx_idles = 1'b1;
    rx_idles = 1'b1;

    // receiver holds off long enough to back the block up into its input
    write_txid(16'($urandom));
    hold_off_req = 1'b1;
    repeat (110) send_address(pick_address());

    write_txid(16'($urandom));
    repeat (120) send_address(pick_address());

    in_valid = 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (DRAIN_TICKS) @(negedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
